>>> rtl/stbs_pkg.sv
// Package for the sorted-table binary search unit.
// Holds field widths, item kinds, controller states and the command/status structs.
// No dependencies.
`default_nettype none

package stbs_pkg;

    localparam int DEF_CAPACITY = 128;
    localparam int KIND_W       = 2;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_SEARCH = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic append;
        logic search_start;
        logic probe;
        logic step;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic table_empty;
        logic last_step;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/stbs_in_if.sv
// Input channel of the sorted-table binary search unit: valid/ready plus kind and value.
// Depends on stbs_pkg.
`default_nettype none

interface stbs_in_if import stbs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic        [KIND_W-1:0]  kind;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/stbs_out_if.sv
// Result channel of the sorted-table binary search unit: valid/ready plus found and position.
// Depends on stbs_pkg.
`default_nettype none

interface stbs_out_if import stbs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;

    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface

`default_nettype wire

>>> rtl/stbs_ctrl.sv
// Controller of the sorted-table binary search unit: sequences accept, probe, compare, emit.
// Depends on stbs_pkg; drives the datapath through t_cmd and reads t_stat.
`default_nettype none

module stbs_ctrl import stbs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [KIND_W-1:0] i_in_kind,
    input  wire t_stat             i_stat,
    output logic                   o_in_ready,
    output t_cmd                   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && (i_in_kind == KIND_SEARCH)) begin
                    n_state = i_stat.table_empty ? S_EMIT : S_PROBE;
                end
            end
            S_PROBE: n_state = S_CMP;
            S_CMP:   n_state = i_stat.last_step ? S_EMIT : S_PROBE;
            S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    // kind 3 is dropped without effect
                    o_cmd.clear        = (i_in_kind == KIND_CLEAR);
                    o_cmd.append       = (i_in_kind == KIND_APPEND);
                    o_cmd.search_start = (i_in_kind == KIND_SEARCH);
                end
            end
            S_PROBE: o_cmd.probe = 1'b1;
            S_CMP:   o_cmd.step  = 1'b1;
            S_EMIT:  o_cmd.emit  = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/stbs_dp.sv
// Datapath of the sorted-table binary search unit: entry memory, count, window, result register.
// Depends on stbs_pkg; commanded by stbs_ctrl through t_cmd.
`default_nettype none

module stbs_dp import stbs_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire t_cmd                      i_cmd,
    input  wire logic                      i_out_ready,
    output t_stat                          o_stat,
    output logic                           o_out_valid,
    output logic                           o_out_found,
    output logic             [POS_W-1:0]   o_out_position
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic signed [VALUE_W-1:0] mem [CAPACITY];

    logic        [CW-1:0]      r_count;
    logic        [CW-1:0]      r_lo;
    logic        [CW-1:0]      r_hi;
    logic        [IW-1:0]      r_mid;
    logic signed [VALUE_W-1:0] r_key;
    logic signed [VALUE_W-1:0] r_rd;
    logic                      r_found;
    logic        [POS_W-1:0]   r_pos;
    logic                      r_out_valid;
    logic                      r_out_found;
    logic        [POS_W-1:0]   r_out_pos;

    logic        [CW:0]        mid_sum;
    logic        [IW-1:0]      mid;
    logic        [CW-1:0]      mid_ext;
    logic        [CW-1:0]      mid_inc;
    logic                      hit;
    logic                      key_above;
    logic                      can_append;

    // mid = floor((lo + hi - 1) / 2); hi > lo whenever a probe is issued
    assign mid_sum    = {1'b0, r_lo} + {1'b0, r_hi} - {{CW{1'b0}}, 1'b1};
    assign mid        = IW'(mid_sum[CW:1]);
    assign mid_ext    = CW'(r_mid);
    assign mid_inc    = mid_ext + {{(CW-1){1'b0}}, 1'b1};
    assign hit        = (r_key == r_rd);
    assign key_above  = (r_key > r_rd);
    assign can_append = (r_count < CW'(CAPACITY));

    assign o_stat.table_empty = (r_count == '0);
    assign o_stat.last_step   = hit || (key_above ? (mid_inc >= r_hi) : (r_lo >= mid_ext));
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && can_append) begin
            mem[r_count[IW-1:0]] <= i_value;
        end
        if (i_cmd.probe) begin
            r_rd <= mem[mid];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.append && can_append) begin
            r_count <= r_count + {{(CW-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.search_start) begin
            r_key   <= i_value;
            r_lo    <= '0;
            r_hi    <= r_count;
            r_found <= 1'b0;
            r_pos   <= '0;
        end
        if (i_cmd.probe) begin
            r_mid <= mid;
        end
        if (i_cmd.step) begin
            priority if (hit) begin
                r_found <= 1'b1;
                r_pos   <= POS_W'(mid_inc);
            end else if (key_above) begin
                r_lo <= mid_inc;
            end else begin
                r_hi <= mid_ext;
            end
        end
    end

    // Result register: hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_found <= r_found;
            r_out_pos   <= r_pos;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_found    = r_out_found;
    assign o_out_position = r_out_pos;

endmodule

`default_nettype wire

>>> rtl/sorted_table_binary_search_unit.sv
// Top level of the sorted-table binary search unit: joins controller and datapath.
// Depends on stbs_pkg, stbs_in_if, stbs_out_if, stbs_ctrl, stbs_dp.
//
//   channel  dir  modport  payload              beats
//   i_in     in   sink     kind[1:0] value[31:0] one per clear, append or search
//   o_out    out  source   found, position[7:0]  one per search
//
// Clear and append are each taken in the idle state. A search is accepted in idle; each
// probe is a registered memory read followed by a compare, and the result is loaded last.
// At most P = floor(log2(count)) + 1 probes are made.
// Reset clears the entry count, controller state and result valid; entries are not cleared.
// A waiting result does not block clear or append beats; a search that finishes while
// the result register is still full holds until it is taken.
`default_nettype none

module sorted_table_binary_search_unit import stbs_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    stbs_in_if.sink    i_in,
    stbs_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    stbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    stbs_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value        (i_in.value),
        .i_cmd          (cmd),
        .i_out_ready    (o_out.ready),
        .o_stat         (stat),
        .o_out_valid    (o_out.valid),
        .o_out_found    (o_out.found),
        .o_out_position (o_out.position)
    );

    assign i_in.ready = in_ready;

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result loaded while result register still full");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.kind == KIND_SEARCH)) |=> !i_in.ready)
        else $error("input accepted while a search is running");

    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |-> (o_out.position == '0))
        else $error("miss reported with nonzero position");

endmodule

`default_nettype wire

>>> tb/tb_sorted_table_binary_search_unit.sv
`timescale 1ns / 100ps
// Testbench for sorted_table_binary_search_unit: drives clear/append/search and kind-3 beats,
// predicts unpinned lookups from its own table copy and checks every result beat in order.
// Depends on stbs_pkg, stbs_in_if, stbs_out_if and the unit itself.

module tb_sorted_table_binary_search_unit;
    import stbs_pkg::*;

    localparam int          CAPACITY    = DEF_CAPACITY;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;
    localparam int          ITEM_TARGET = 950;
    localparam int          IDLE_PCT    = 22;
    localparam int          HOLD_AT     = 1500;
    localparam int          HOLD_SPAN   = 400;
    localparam int          CALM_FROM   = 2200;
    localparam int          CALM_TO     = 3200;
    localparam int          STALL_LIMIT = 2000;
    localparam int          DRAIN       = 40;
    localparam int          PRINT_CAP   = 50;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } lookup_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               pinned;
        lookup_t            want;
    } row_t;

    localparam lookup_t NO_HIT = '0;

    logic clk = 1'b0;
    logic rst_n;

    stbs_in_if  in_ch ();
    stbs_out_if out_ch ();

    sorted_table_binary_search_unit #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow copy of the table and the lookups still owed by the unit
    logic signed [VALUE_W-1:0] shadow_tbl [CAPACITY];
    int unsigned               shadow_count = 0;
    lookup_t                   pending_lookups [$];

    // Tags that ride along with the payload: a hand-typed expectation for this beat
    logic    pin_on;
    lookup_t pin_want;

    int  mismatches   = 0;
    int  beats_sent   = 0;
    int  stall_cycles = 0;
    int  cyc          = 0;
    wire calm         = (cyc >= CALM_FROM) && (cyc < CALM_TO);

    row_t directed_rows [0:24] = '{
        '{KIND_SEARCH, 32'sd0,   1'b1, NO_HIT},         // empty table after reset
        '{KIND_UNUSED, VAL_MAX,  1'b0, NO_HIT},
        '{KIND_APPEND, VAL_MIN,  1'b0, NO_HIT},
        '{KIND_APPEND, -32'sd1,  1'b0, NO_HIT},
        '{KIND_APPEND, 32'sd0,   1'b0, NO_HIT},
        '{KIND_APPEND, VAL_MAX,  1'b0, NO_HIT},
        '{KIND_SEARCH, VAL_MIN,  1'b1, '{1'b1, 8'd1}},
        '{KIND_SEARCH, VAL_MAX,  1'b1, '{1'b1, 8'd4}},
        '{KIND_SEARCH, -32'sd1,  1'b1, '{1'b1, 8'd2}},
        '{KIND_SEARCH, 32'sd0,   1'b1, '{1'b1, 8'd3}},
        '{KIND_SEARCH, 32'sd1,   1'b1, NO_HIT},
        '{KIND_SEARCH, VAL_MIN + 32'sd1, 1'b0, NO_HIT},
        '{KIND_CLEAR,  32'sd0,   1'b0, NO_HIT},
        '{KIND_SEARCH, -32'sd1,  1'b1, NO_HIT},         // stale entries must not match
        '{KIND_UNUSED, 32'sd0,   1'b0, NO_HIT},
        '{KIND_APPEND, 32'sd5,   1'b0, NO_HIT},
        '{KIND_SEARCH, 32'sd5,   1'b1, '{1'b1, 8'd1}},
        '{KIND_SEARCH, 32'sd4,   1'b1, NO_HIT},
        '{KIND_CLEAR,  VAL_MAX,  1'b0, NO_HIT},
        '{KIND_APPEND, 32'sd30,  1'b0, NO_HIT},         // unsorted table
        '{KIND_APPEND, 32'sd10,  1'b0, NO_HIT},
        '{KIND_APPEND, 32'sd20,  1'b0, NO_HIT},
        '{KIND_SEARCH, 32'sd10,  1'b0, NO_HIT},
        '{KIND_SEARCH, 32'sd30,  1'b0, NO_HIT},
        '{KIND_SEARCH, 32'sd20,  1'b0, NO_HIT}
    };

    task automatic note_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Walk the same probe order as the unit: midpoint of [lo, hi-1] until hit or empty
    function automatic lookup_t probe_shadow(input logic signed [VALUE_W-1:0] key);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lookup_t     res;
        res = NO_HIT;
        lo  = 0;
        hi  = shadow_count;
        while (lo < hi && !res.found) begin
            mid = (lo + hi - 1) / 2;
            if (key == shadow_tbl[mid]) begin
                res.found    = 1'b1;
                res.position = POS_W'(mid + 1);
            end else if (key > shadow_tbl[mid]) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return res;
    endfunction

    // Offer one beat, with random gaps ahead of it, and return at the edge that takes it
    task automatic offer(input logic [KIND_W-1:0] k, input logic signed [VALUE_W-1:0] v,
                         input logic pinned, input lookup_t want);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind  <= k;
        in_ch.value <= v;
        pin_on      <= pinned;
        pin_want    <= want;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (k != KIND_UNUSED)
            beats_sent++;
    endtask

    // Clear (optionally), fill, then search mostly for keys that were appended
    task automatic play_sequence(input int n_append, input bit do_clear, input bit sorted_fill,
                                 input int n_search);
        int                        vals [$];
        int                        i;
        int                        r;
        bit                        narrow;
        logic signed [VALUE_W-1:0] key;
        narrow = ($urandom_range(99) < 25);
        for (i = 0; i < n_append; i++) begin
            if (narrow)
                vals.push_back(int'($urandom_range(40)) - 20);
            else
                vals.push_back(int'($urandom));
        end
        if (sorted_fill)
            vals.sort();
        if (do_clear)
            offer(KIND_CLEAR, $urandom, 1'b0, NO_HIT);
        for (i = 0; i < n_append; i++) begin
            if ($urandom_range(99) < 3)
                offer(KIND_UNUSED, $urandom, 1'b0, NO_HIT);
            offer(KIND_APPEND, vals[i], 1'b0, NO_HIT);
        end
        for (i = 0; i < n_search; i++) begin
            r = $urandom_range(99);
            if (r < 60 && vals.size() > 0) begin
                key = vals[$urandom_range(vals.size() - 1)];
            end else if (r < 75 && vals.size() > 0) begin
                key = vals[$urandom_range(vals.size() - 1)];
                key = $urandom_range(1) ? key + 32'sd1 : key - 32'sd1;
            end else if (r < 85) begin
                case ($urandom_range(3))
                    0:       key = VAL_MIN;
                    1:       key = VAL_MAX;
                    2:       key = 32'sd0;
                    default: key = -32'sd1;
                endcase
            end else begin
                key = $urandom;
            end
            offer(KIND_SEARCH, key, 1'b0, NO_HIT);
        end
    endtask

    initial begin : stimulus
        int i;
        int r;
        in_ch.valid <= 1'b0;
        in_ch.kind  <= KIND_CLEAR;
        in_ch.value <= '0;
        pin_on      <= 1'b0;
        pin_want    <= NO_HIT;
        rst_n       <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < $size(directed_rows); i++)
            offer(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].pinned,
                  directed_rows[i].want);

        // Overfill: the last appends must be dropped
        play_sequence(CAPACITY + 2, 1'b1, 1'b1, 10);

        while (beats_sent < ITEM_TARGET) begin
            r = $urandom_range(99);
            if (r < 3) begin
                play_sequence(CAPACITY + $urandom_range(4), 1'b1, 1'b1, $urandom_range(4, 10));
            end else if (r < 80) begin
                play_sequence($urandom_range(20), $urandom_range(99) < 85, 1'b1,
                              $urandom_range(1, 8));
            end else if (r < 90) begin
                play_sequence($urandom_range(1, 12), 1'b1, 1'b0, $urandom_range(1, 6));
            end else begin
                repeat ($urandom_range(1, 4))
                    offer(KIND_W'($urandom_range(3)), $urandom, 1'b0, NO_HIT);
            end
        end
        in_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending_lookups.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (pending_lookups.size() != 0)
            note_mismatch($sformatf("%0d lookups never answered", pending_lookups.size()));

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Result side: random stalls, one long hold-off so the unit backs up into its input
    initial begin : result_sink
        int seen;
        seen = 0;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (seen == HOLD_AT) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_SPAN) @(posedge clk);
            end
            out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            seen++;
            @(posedge clk);
        end
    end

    always @(posedge clk) begin : beat_monitor
        bit      moved;
        lookup_t want;
        cyc <= cyc + 1;
        if (rst_n) begin
            moved = 1'b0;
            if (in_ch.valid && in_ch.ready) begin
                moved = 1'b1;
                case (in_ch.kind)
                    KIND_CLEAR: begin
                        shadow_count = 0;
                    end
                    KIND_APPEND: begin
                        if (shadow_count < CAPACITY) begin
                            shadow_tbl[shadow_count] = in_ch.value;
                            shadow_count++;
                        end
                    end
                    KIND_SEARCH: begin
                        pending_lookups.push_back(pin_on ? pin_want : probe_shadow(in_ch.value));
                    end
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                moved = 1'b1;
                if (pending_lookups.size() == 0) begin
                    note_mismatch($sformatf("unexpected result found=%0b position=%0d",
                                            out_ch.found, out_ch.position));
                end else begin
                    want = pending_lookups.pop_front();
                    if (out_ch.found !== want.found)
                        note_mismatch($sformatf("found %0b, expected %0b",
                                                out_ch.found, want.found));
                    if (out_ch.position !== want.position)
                        note_mismatch($sformatf("position %0d, expected %0d",
                                                out_ch.position, want.position));
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule
